// File: rtl/mcsn_pkg.sv
// ----------------------------------------------------------------------------
// mcsn_pkg
// Shared types and constants for the multichannel sine oscillator: controller
// states, datapath command and status bundles, polynomial coefficients.
// ----------------------------------------------------------------------------
package mcsn_pkg;

  // stream field widths fixed by the item format
  localparam int unsigned CH_W       = 5;
  localparam int unsigned STEP_W     = 32;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned IN_USER_W  = 6;

  // quarter-wave sine arithmetic, Q30
  localparam int unsigned Q30_W = 31;
  localparam int unsigned ACC_W = 33;
  localparam int unsigned PROD_W = 63;

  localparam logic signed [ACC_W-1:0] Q30_ONE = 33'sd1073741824;
  localparam logic signed [ACC_W-1:0] K1  = 33'sd1686629713;
  localparam logic signed [ACC_W-1:0] K3  = 33'sd693598669;
  localparam logic signed [ACC_W-1:0] K5  = 33'sd85569306;
  localparam logic signed [ACC_W-1:0] K7  = 33'sd5026995;
  localparam logic signed [ACC_W-1:0] K9  = 33'sd172271;
  localparam logic signed [ACC_W-1:0] K11 = 33'sd3864;

  // horner steps after the seed value
  localparam int unsigned HORNER_STEPS = 5;
  localparam logic [2:0]  HORNER_LAST  = 3'(HORNER_STEPS - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_ADV,
    ST_FOLD,
    ST_MUL_ZZ,
    ST_POST_ZZ,
    ST_MUL_H,
    ST_POST_H,
    ST_MUL_Z,
    ST_POST_Z,
    ST_MUL_G,
    ST_OUT
  } mcsn_state_t;

  typedef enum logic [1:0] {
    MS_ZZ,
    MS_ACC_Z2,
    MS_ACC_Z,
    MS_GAIN
  } mcsn_mul_sel_t;

  typedef enum logic [1:0] {
    PO_NONE,
    PO_Z2,
    PO_HORNER,
    PO_FINAL
  } mcsn_post_t;

  typedef struct packed {
    logic          clear;
    logic          capture;
    logic          read;
    logic          advance;
    logic          fold;
    logic          mul_en;
    mcsn_mul_sel_t mul_sel;
    mcsn_post_t    post;
    logic [2:0]    coef_idx;
    logic          out_load;
  } mcsn_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } mcsn_status_t;

  // coefficient added at each horner step, highest order first
  function automatic logic signed [ACC_W-1:0] horner_coef(input logic [2:0] idx);
    logic signed [ACC_W-1:0] c;
    unique case (idx)
      3'd0:    c = K9;
      3'd1:    c = -K7;
      3'd2:    c = K5;
      3'd3:    c = -K3;
      3'd4:    c = K1;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/mcsn_ctrl.sv
// ----------------------------------------------------------------------------
// mcsn_ctrl
// Sequencer for the oscillator: clears the phase store after reset, takes one
// request at a time and steps the datapath through phase update and sine.
// ----------------------------------------------------------------------------
module mcsn_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  mcsn_pkg::mcsn_status_t status,
  output mcsn_pkg::mcsn_cmd_t    cmd
);
  import mcsn_pkg::*;

  mcsn_state_t state, state_next;
  logic [2:0]  k, k_next;

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    k_next       = k;
    s_tready     = 1'b0;
    cmd          = '0;
    cmd.mul_sel  = MS_ZZ;
    cmd.post     = PO_NONE;
    cmd.coef_idx = k;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_ADV;
      end
      ST_ADV: begin
        cmd.advance = 1'b1;
        state_next  = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = ST_MUL_ZZ;
      end
      ST_MUL_ZZ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_ZZ;
        state_next  = ST_POST_ZZ;
      end
      ST_POST_ZZ: begin
        cmd.post   = PO_Z2;
        k_next     = '0;
        state_next = ST_MUL_H;
      end
      ST_MUL_H: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_ACC_Z2;
        state_next  = ST_POST_H;
      end
      ST_POST_H: begin
        cmd.post = PO_HORNER;
        if (k == HORNER_LAST) begin
          state_next = ST_MUL_Z;
        end else begin
          k_next     = k + 3'd1;
          state_next = ST_MUL_H;
        end
      end
      ST_MUL_Z: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_ACC_Z;
        state_next  = ST_POST_Z;
      end
      ST_POST_Z: begin
        cmd.post   = PO_FINAL;
        state_next = ST_MUL_G;
      end
      ST_MUL_G: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_GAIN;
        state_next  = ST_OUT;
      end
      ST_OUT: begin
        // wait for the output register to free up
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/mcsn_dp.sv
// ----------------------------------------------------------------------------
// mcsn_dp
// Datapath: per-channel phase store, phase fold, one shared multiplier for the
// sine polynomial and gain, rounding, saturation and the output register.
// ----------------------------------------------------------------------------
module mcsn_dp #(
  parameter  int unsigned CHANNELS    = 32,
  parameter  int unsigned PHASE_BITS  = 32,
  parameter  int unsigned SAMPLE_BITS = 16,
  localparam int unsigned OUT_W       = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mcsn_pkg::mcsn_cmd_t               cmd,
  output mcsn_pkg::mcsn_status_t            status,
  input  logic [mcsn_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic [mcsn_pkg::IN_USER_W-1:0]   s_tuser,
  input  logic                             m_tready,
  output logic                             m_tvalid,
  output logic [OUT_W-1:0]                 m_tdata
);
  import mcsn_pkg::*;

  localparam int unsigned AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PB    = PHASE_BITS;
  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned CW    = AW + CH_W;
  localparam int          SH    = int'(PB) - 32;
  localparam int unsigned STEP_L = (SH > 0) ? SH : 0;
  localparam int unsigned STEP_R = (SH < 0) ? -SH : 0;
  localparam int          ZS    = int'(PB) - 32;
  localparam int unsigned Z_R   = (ZS > 0) ? ZS : 0;
  localparam int unsigned Z_L   = (ZS < 0) ? -ZS : 0;
  localparam int unsigned RSHIFT = 46 - SB;
  localparam logic [63:0] RND     = 64'(1) << (RSHIFT - 1);
  localparam logic [63:0] POS_MAX = (64'(1) << (SB - 1)) - 64'(1);
  localparam logic [PB-2:0] QUARTER = (PB-1)'(1) << (PB - 2);

  // phase store
  logic [PB-1:0] phase_mem [CHANNELS];

  logic [AW-1:0]    clr_addr;
  logic [AW-1:0]    ch_addr;
  logic             ch_ok;
  logic             restart_q;
  logic [PB-1:0]    step_al;
  logic [GAIN_W-1:0] gain_q;
  logic [PB-1:0]    rd_phase;
  logic [PB-1:0]    phase;
  logic             neg;
  logic [Q30_W-1:0] z, z2, s;
  logic signed [ACC_W-1:0] acc;
  logic [PROD_W-1:0] prod;
  logic             prod_neg;
  logic             m_valid;
  logic [OUT_W-1:0] m_data;

  // request fields
  logic [CH_W-1:0]  ch_in;
  logic [CW-1:0]    ch_ext;
  logic [63:0]      step_w;
  logic [PB-1:0]    phase_sum;
  logic [PB-2:0]    h;
  logic [PB-1:0]    h_mirror;
  logic [PB-2:0]    q;
  logic [63:0]      z_w;

  assign ch_in  = s_tuser[CH_W-1:0];
  assign ch_ext = CW'(ch_in);
  assign step_w = (64'(s_tdata[STEP_W-1:0]) << STEP_L) >> STEP_R;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch_addr   <= ch_ext[AW-1:0];
      ch_ok     <= (ch_ext < CW'(CHANNELS));
      restart_q <= s_tuser[CH_W];
      step_al   <= step_w[PB-1:0];
      gain_q    <= s_tdata[STEP_W +: GAIN_W];
    end
  end

  // clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign phase_sum = (restart_q ? '0 : rd_phase) + step_al;

  // store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      phase_mem[clr_addr] <= '0;
    end else if (cmd.advance && ch_ok) begin
      phase_mem[ch_addr] <= phase_sum;
    end
    if (cmd.read) rd_phase <= phase_mem[ch_addr];
  end

  // half-wave fold to a quarter-wave argument in Q30
  assign h        = phase[PB-2:0];
  assign h_mirror = {1'b1, {(PB-1){1'b0}}} - {1'b0, h};
  assign q        = (h < QUARTER) ? h : h_mirror[PB-2:0];
  assign z_w      = (64'(q) >> Z_R) << Z_L;

  always_ff @(posedge clk) begin
    if (cmd.advance) phase <= phase_sum;
    if (cmd.fold) begin
      neg <= phase[PB-1];
      z   <= z_w[Q30_W-1:0];
    end
  end

  // shared multiplier operand select
  logic              acc_neg;
  logic [ACC_W-1:0]  acc_abs;
  logic [31:0]       mul_a;
  logic [Q30_W-1:0]  mul_b;
  logic              mul_n;

  assign acc_neg = acc[ACC_W-1];
  assign acc_abs = acc_neg ? 33'(-acc) : 33'(acc);

  always_comb begin
    case (cmd.mul_sel)
      MS_ZZ: begin
        mul_a = 32'(z);
        mul_b = z;
        mul_n = 1'b0;
      end
      MS_ACC_Z2: begin
        mul_a = acc_abs[31:0];
        mul_b = z2;
        mul_n = acc_neg;
      end
      MS_ACC_Z: begin
        mul_a = acc_abs[31:0];
        mul_b = z;
        mul_n = acc_neg;
      end
      MS_GAIN: begin
        mul_a = 32'(s);
        mul_b = Q30_W'(gain_q);
        mul_n = 1'b0;
      end
      default: begin
        mul_a = 32'(z);
        mul_b = z;
        mul_n = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod     <= PROD_W'(mul_a) * PROD_W'(mul_b);
      prod_neg <= mul_n;
    end
  end

  // q30 rescale with truncation toward zero
  logic [ACC_W-1:0]        shifted;
  logic signed [ACC_W-1:0] pval;

  assign shifted = prod[PROD_W-1:30];
  assign pval    = prod_neg ? -$signed(shifted) : $signed(shifted);

  always_ff @(posedge clk) begin
    case (cmd.post)
      PO_Z2: begin
        z2  <= prod[60:30];
        acc <= -K11;
      end
      PO_HORNER: begin
        acc <= horner_coef(cmd.coef_idx) + pval;
      end
      PO_FINAL: begin
        if (pval < 0) begin
          s <= '0;
        end else if (pval > Q30_ONE) begin
          s <= Q30_W'(Q30_ONE);
        end else begin
          s <= pval[Q30_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // round half up, apply sign, saturate
  logic [63:0]   rounded;
  logic [63:0]   mag;
  logic [63:0]   lim;
  logic [63:0]   res_w;
  logic [SB-1:0] sample;

  assign rounded = 64'(prod) + RND;
  assign mag     = rounded >> RSHIFT;

  always_comb begin
    if (neg) begin
      lim   = (mag > POS_MAX + 64'(1)) ? POS_MAX + 64'(1) : mag;
      res_w = 64'(0) - lim;
    end else begin
      lim   = (mag > POS_MAX) ? POS_MAX : mag;
      res_w = lim;
    end
    sample = ch_ok ? res_w[SB-1:0] : '0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (cmd.out_load) begin
      m_valid <= 1'b1;
    end else if (m_tready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) m_data <= OUT_W'(sample);
  end

  assign m_tvalid          = m_valid;
  assign m_tdata           = m_data;
  assign status.clear_last = (clr_addr == AW'(CHANNELS - 1));
  assign status.out_free   = !m_valid || m_tready;

endmodule

// File: rtl/multichannel_sine_nco.sv
// ----------------------------------------------------------------------------
// multichannel_sine_nco
// Multichannel sine oscillator: one phase accumulator per channel, half-wave
// folded polynomial sine, gain scaling and saturation to full scale.
// ----------------------------------------------------------------------------
// one request at a time, taken only while idle; a shared 32x31 multiplier forms
//   eight products per sample, each followed by a rescale step where needed
// reset: synchronous; the phase store is then swept to zero, one channel per
//   cycle, with s_axis_tready low until the sweep ends
module multichannel_sine_nco #(
  parameter  int unsigned CHANNELS    = 32,
  parameter  int unsigned PHASE_BITS  = 32,
  parameter  int unsigned SAMPLE_BITS = 16,
  localparam int unsigned OUT_W       = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mcsn_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // phase_step[31:0], gain[47:32]
  input  logic [mcsn_pkg::IN_USER_W-1:0]  s_axis_tuser,  // channel[4:0], restart[5]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [OUT_W-1:0]                m_axis_tdata   // sample_out[SAMPLE_BITS-1:0]
);
  import mcsn_pkg::*;

  mcsn_cmd_t    cmd;
  mcsn_status_t status;

  // sequencer
  mcsn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // phase store, sine and output datapath
  mcsn_dp #(
    .CHANNELS    (CHANNELS),
    .PHASE_BITS  (PHASE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_axis_tdata),
    .s_tuser  (s_axis_tuser),
    .m_tready (m_axis_tready),
    .m_tvalid (m_axis_tvalid),
    .m_tdata  (m_axis_tdata)
  );

endmodule
